// File: rtl/cltok_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command line tokenizer package
// Shared types, codes and command name tables for the tokenizer block.
// ----------------------------------------------------------------------------
package cltok_pkg;

  localparam logic [2:0] PH_VERB = 3'd0;
  localparam logic [2:0] PH_GAP  = 3'd1;
  localparam logic [2:0] PH_QKEY = 3'd2;
  localparam logic [2:0] PH_BARE = 3'd3;
  localparam logic [2:0] PH_WGAP = 3'd4;
  localparam logic [2:0] PH_WVAL = 3'd5;
  localparam logic [2:0] PH_DONE = 3'd6;

  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [2:0] CODE_UNKNOWN = 3'd0;
  localparam logic [2:0] CODE_PRINT   = 3'd1;
  localparam logic [2:0] CODE_CLEAR   = 3'd2;
  localparam logic [2:0] CODE_READ    = 3'd3;
  localparam logic [2:0] CODE_WRITE   = 3'd4;
  localparam logic [2:0] CODE_FORGET  = 3'd5;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;

  localparam int         NUM_VERBS   = 5;
  localparam logic [3:0] POS_MAX     = 4'd15;
  localparam logic [4:0] ALL_NAMES   = 5'b11111;

  localparam logic       REG_TOKEN_LIMIT   = 1'b0;
  localparam logic [7:0] TOKEN_LIMIT_RESET = 8'd32;

  localparam logic [7:0] VERB_NAME [0:4][0:5] = '{
    '{"P", "R", "I", "N", "T", 8'h00},
    '{"C", "L", "E", "A", "R", 8'h00},
    '{"R", "E", "A", "D", 8'h00, 8'h00},
    '{"W", "R", "I", "T", "E", 8'h00},
    '{"F", "O", "R", "G", "E", "T"}
  };

  localparam logic [3:0] VERB_LEN [0:4] = '{4'd5, 4'd5, 4'd4, 4'd5, 4'd6};

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] token_char;
    logic [2:0] command;
    logic [7:0] key_length;
    logic [7:0] value_length;
  } res_t;

  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } res_pair_t;

  function automatic logic [7:0] verb_char(input int k, input logic [3:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (pos < 4'd6) begin
      ch = VERB_NAME[k][pos[2:0]];
    end
    return ch;
  endfunction

  function automatic logic [4:0] finish_mask(input logic [4:0] cand,
                                             input logic [3:0] pos);
    logic [4:0] m;
    for (int k = 0; k < NUM_VERBS; k++) begin
      m[k] = cand[k] & (VERB_LEN[k] == pos);
    end
    return m;
  endfunction

  function automatic logic [2:0] cmd_of(input logic [4:0] cand);
    logic [2:0] c;
    c = CODE_UNKNOWN;
    for (int k = NUM_VERBS - 1; k >= 0; k--) begin
      if (cand[k]) begin
        c = 3'(k + 1);
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/cltok_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer channel interfaces
// Character input channel and token result channel with valid/ready.
// ----------------------------------------------------------------------------
interface cltok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink (input valid, char_code, last_char, output ready);
endinterface

interface cltok_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] token_char;
  logic [2:0] command;
  logic [7:0] key_length;
  logic [7:0] value_length;

  modport source (output valid, kind, token_char, command, key_length, value_length,
                  input ready);
  modport sink (input valid, kind, token_char, command, key_length, value_length,
                output ready);
endinterface

// File: rtl/cltok_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer configuration registers
// APB-style register file holding the token length limit.
// ----------------------------------------------------------------------------
module cltok_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  token_limit
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == cltok_pkg::REG_TOKEN_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      token_limit <= cltok_pkg::TOKEN_LIMIT_RESET;
    end else if (wr_en) begin
      token_limit <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == cltok_pkg::REG_TOKEN_LIMIT) begin
      prdata = {24'd0, token_limit};
    end
  end

endmodule

// File: rtl/cltok_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer parser
// Input register and phase machine that matches the command and pulls tokens.
// ----------------------------------------------------------------------------
module cltok_parse (
  input  logic                 clk,
  input  logic                 rst,
  cltok_in_if.sink             char_in,
  input  logic [7:0]           token_limit,
  input  logic                 space_ok,
  output cltok_pkg::res_pair_t push
);

  logic       s_valid;
  logic [7:0] s_char;
  logic       s_last;
  logic       adv;

  logic [2:0] phase, phase_next;
  logic [4:0] cand, cand_next;
  logic [3:0] pos, pos_next;
  logic [7:0] key_count, key_count_next;
  logic [7:0] value_count, value_count_next;
  logic       line_ended, line_ended_next;

  logic       ch_v;
  logic [1:0] ch_kind;
  logic       fin;
  logic [2:0] cmd_cur;
  logic [2:0] fin_cmd;
  logic [7:0] fin_key;
  logic [7:0] fin_value;
  cltok_pkg::res_t ch_res, fin_res;

  assign adv           = s_valid && space_ok;
  assign char_in.ready = !s_valid || space_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (char_in.valid && char_in.ready) begin
      s_valid <= 1'b1;
    end else if (adv) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.valid && char_in.ready) begin
      s_char <= char_in.char_code;
      s_last <= char_in.last_char;
    end
  end

  always_comb begin
    phase_next       = phase;
    cand_next        = cand;
    pos_next         = pos;
    key_count_next   = key_count;
    value_count_next = value_count;
    line_ended_next  = line_ended;
    ch_v             = 1'b0;
    ch_kind          = cltok_pkg::KIND_KEY;
    fin              = 1'b0;
    fin_cmd          = cltok_pkg::CODE_UNKNOWN;
    fin_key          = 8'd0;
    fin_value        = 8'd0;
    cmd_cur          = cltok_pkg::cmd_of(cand);

    if (line_ended) begin
      if (s_last) begin
        line_ended_next = 1'b0;
      end
    end else begin
      if (s_char != cltok_pkg::CHAR_NUL) begin
        case (phase)
          cltok_pkg::PH_VERB: begin
            if (s_char == cltok_pkg::CHAR_SPACE) begin
              cand_next  = cltok_pkg::finish_mask(cand, pos);
              phase_next = (cltok_pkg::cmd_of(cand_next) >= cltok_pkg::CODE_READ) ?
                           cltok_pkg::PH_GAP : cltok_pkg::PH_DONE;
            end else begin
              for (int k = 0; k < cltok_pkg::NUM_VERBS; k++) begin
                if (cltok_pkg::verb_char(k, pos) != s_char) begin
                  cand_next[k] = 1'b0;
                end
              end
              if (pos < cltok_pkg::POS_MAX) begin
                pos_next = pos + 4'd1;
              end
            end
          end
          cltok_pkg::PH_GAP: begin
            if (s_char != cltok_pkg::CHAR_SPACE) begin
              if (cmd_cur == cltok_pkg::CODE_WRITE) begin
                phase_next = (s_char == cltok_pkg::CHAR_QUOTE) ?
                             cltok_pkg::PH_QKEY : cltok_pkg::PH_DONE;
              end else if (cmd_cur == cltok_pkg::CODE_READ &&
                           s_char == cltok_pkg::CHAR_QUOTE) begin
                phase_next = cltok_pkg::PH_QKEY;
              end else if (key_count < token_limit) begin
                phase_next     = cltok_pkg::PH_BARE;
                ch_v           = 1'b1;
                key_count_next = key_count + 8'd1;
              end else begin
                phase_next = cltok_pkg::PH_DONE;
              end
            end
          end
          cltok_pkg::PH_QKEY: begin
            if (s_char == cltok_pkg::CHAR_QUOTE) begin
              phase_next = (cmd_cur == cltok_pkg::CODE_WRITE) ?
                           cltok_pkg::PH_WGAP : cltok_pkg::PH_DONE;
            end else if (key_count < token_limit) begin
              ch_v           = 1'b1;
              key_count_next = key_count + 8'd1;
            end else begin
              phase_next = (cmd_cur == cltok_pkg::CODE_WRITE &&
                            s_char == cltok_pkg::CHAR_SPACE) ?
                           cltok_pkg::PH_WGAP : cltok_pkg::PH_DONE;
            end
          end
          cltok_pkg::PH_BARE: begin
            if (s_char == cltok_pkg::CHAR_SPACE) begin
              phase_next = cltok_pkg::PH_DONE;
            end else if (key_count < token_limit) begin
              ch_v           = 1'b1;
              key_count_next = key_count + 8'd1;
            end else begin
              phase_next = cltok_pkg::PH_DONE;
            end
          end
          cltok_pkg::PH_WGAP: begin
            if (s_char != cltok_pkg::CHAR_SPACE) begin
              phase_next = (s_char == cltok_pkg::CHAR_QUOTE) ?
                           cltok_pkg::PH_WVAL : cltok_pkg::PH_DONE;
            end
          end
          cltok_pkg::PH_WVAL: begin
            if (s_char == cltok_pkg::CHAR_QUOTE) begin
              phase_next = cltok_pkg::PH_DONE;
            end else if (value_count < token_limit) begin
              ch_v             = 1'b1;
              ch_kind          = cltok_pkg::KIND_VALUE;
              value_count_next = value_count + 8'd1;
            end else begin
              phase_next = cltok_pkg::PH_DONE;
            end
          end
          default: begin
            phase_next = cltok_pkg::PH_DONE;
          end
        endcase
      end

      if (s_char == cltok_pkg::CHAR_NUL || s_last) begin
        fin = 1'b1;
        if (phase_next == cltok_pkg::PH_VERB) begin
          cand_next = cltok_pkg::finish_mask(cand_next, pos_next);
        end
        fin_cmd          = cltok_pkg::cmd_of(cand_next);
        fin_key          = key_count_next;
        fin_value        = value_count_next;
        phase_next       = cltok_pkg::PH_VERB;
        cand_next        = cltok_pkg::ALL_NAMES;
        pos_next         = 4'd0;
        key_count_next   = 8'd0;
        value_count_next = 8'd0;
        if (s_char == cltok_pkg::CHAR_NUL && !s_last) begin
          line_ended_next = 1'b1;
        end
      end
    end
  end

  always_comb begin
    ch_res.kind          = ch_kind;
    ch_res.token_char    = s_char;
    ch_res.command       = cltok_pkg::CODE_UNKNOWN;
    ch_res.key_length    = 8'd0;
    ch_res.value_length  = 8'd0;
    fin_res.kind         = cltok_pkg::KIND_END;
    fin_res.token_char   = 8'd0;
    fin_res.command      = fin_cmd;
    fin_res.key_length   = fin_key;
    fin_res.value_length = fin_value;

    push.v0 = adv && (ch_v || fin);
    push.v1 = adv && ch_v && fin;
    push.r0 = ch_v ? ch_res : fin_res;
    push.r1 = fin_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= cltok_pkg::PH_VERB;
      cand        <= cltok_pkg::ALL_NAMES;
      pos         <= 4'd0;
      key_count   <= 8'd0;
      value_count <= 8'd0;
      line_ended  <= 1'b0;
    end else if (adv) begin
      phase       <= phase_next;
      cand        <= cand_next;
      pos         <= pos_next;
      key_count   <= key_count_next;
      value_count <= value_count_next;
      line_ended  <= line_ended_next;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= cltok_pkg::PH_DONE)
    else $error("parser phase out of range");

  a_ended_clear: assert property (@(posedge clk) disable iff (rst)
    line_ended |-> (phase == cltok_pkg::PH_VERB && key_count == 8'd0 &&
                    value_count == 8'd0 && pos == 4'd0))
    else $error("line state not cleared while skipping to line end");

  a_key_cap: assert property (@(posedge clk) disable iff (rst)
    (adv && ch_v && ch_kind == cltok_pkg::KIND_KEY) |-> (key_count < token_limit))
    else $error("key character taken beyond the token limit");

endmodule

// File: rtl/cltok_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer result queue
// Four-entry queue that takes up to two result words per cycle.
// ----------------------------------------------------------------------------
module cltok_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  cltok_pkg::res_pair_t push,
  output logic                 space_ok,
  cltok_out_if.source          token_out
);

  cltok_pkg::res_t mem [0:3];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count, count_next;
  logic       pop;
  cltok_pkg::res_t head;

  assign pop      = token_out.valid && token_out.ready;
  assign space_ok = (count <= 3'd2);
  assign head     = mem[rptr];

  assign token_out.valid        = (count != 3'd0);
  assign token_out.kind         = head.kind;
  assign token_out.token_char   = head.token_char;
  assign token_out.command      = head.command;
  assign token_out.key_length   = head.key_length;
  assign token_out.value_length = head.value_length;

  assign count_next = count + {2'd0, push.v0} + {2'd0, push.v1} - {2'd0, pop};

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wptr] <= push.r0;
    end
    if (push.v1) begin
      mem[wptr + 2'd1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 2'd0;
      rptr  <= 2'd0;
      count <= 3'd0;
    end else begin
      wptr  <= wptr + {1'b0, push.v0} + {1'b0, push.v1};
      rptr  <= rptr + {1'b0, pop};
      count <= count_next;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("result queue count beyond depth");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.v1 |-> push.v0)
    else $error("second result word pushed without the first");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.v0 |-> (count <= 3'd2))
    else $error("result word pushed without room for a pair");

endmodule

// File: rtl/command_line_tokenizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command line tokenizer core
// Matches the command word of a line and streams out key and value tokens.
// ----------------------------------------------------------------------------
//  channel    | dir | handshake     | word
//  char_in    | in  | valid/ready   | char_code[7:0], last_char
//  token_out  | out | valid/ready   | kind, token_char, command, key_length,
//             |     |               | value_length
//  apb        | in  | psel/penable  | token_limit at byte address 0
//
// One character word is taken per cycle while the result queue has room.
// It is registered on input; its result words go through the result queue.
// A key or value character that also ends the line yields two result words;
// the four-word queue drains at one word per cycle while token_out is ready.
// The parser stalls while the result queue holds more than two words.
// Synchronous reset clears the line state and sets token_limit to 32.
// ----------------------------------------------------------------------------
module command_line_tokenizer_core (
  input  logic        clk,
  input  logic        rst,
  cltok_in_if.sink    char_in,
  cltok_out_if.source token_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]           token_limit;
  logic                 space_ok;
  cltok_pkg::res_pair_t push;

  cltok_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .token_limit (token_limit)
  );

  cltok_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .char_in     (char_in),
    .token_limit (token_limit),
    .space_ok    (space_ok),
    .push        (push)
  );

  cltok_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space_ok  (space_ok),
    .token_out (token_out)
  );

endmodule

// File: tb/sv/command_line_tokenizer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command line tokenizer testbench
// Streams command lines into the tokenizer and checks every result word
// against a line-level prediction of verb matching, key and value extraction,
// token capping and zero-byte line endings, under random source gaps and
// sink stalls and several token limits.
// ----------------------------------------------------------------------------
module command_line_tokenizer_core_tb;

  typedef logic [7:0] line_t [$];

  localparam int STUCK_LIMIT = 2000;
  localparam int ITEM_TARGET = 550;
  localparam logic [2:0] LIMIT_ADDR = {cltok_pkg::REG_TOKEN_LIMIT, 2'b00};
  localparam logic [2:0] VERB_CMD [5] = '{cltok_pkg::CODE_PRINT, cltok_pkg::CODE_CLEAR,
                                          cltok_pkg::CODE_READ, cltok_pkg::CODE_WRITE,
                                          cltok_pkg::CODE_FORGET};

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cltok_in_if  in_ch ();
  cltok_out_if out_ch ();

  command_line_tokenizer_core DUT (
    .clk       (clk),
    .rst       (rst),
    .char_in   (in_ch),
    .token_out (out_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Line state of the tokenizer as the testbench sees it.
  logic [2:0] tok_phase;
  logic [4:0] name_mask;
  logic [3:0] word_pos;
  logic [7:0] key_count;
  logic [7:0] value_count;
  bit         skip_rest;
  logic [7:0] cur_limit;

  cltok_pkg::res_t pending_words [$];

  int  fail_count = 0;
  int  chars_sent = 0;
  int  lines_sent = 0;
  int  key_words = 0;
  int  value_words = 0;
  int  end_words = 0;
  int  limits_used = 0;
  int  burst_left = 0;
  int  stuck_cycles = 0;
  bit  source_idle = 1'b0;
  bit  sink_busy = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic string verb_spelling(input int k);
    case (k)
      0: return "PRINT";
      1: return "CLEAR";
      2: return "READ";
      3: return "WRITE";
      default: return "FORGET";
    endcase
  endfunction

  function automatic int verb_length(input int k);
    string w;
    w = verb_spelling(k);
    return w.len();
  endfunction

  function automatic logic [7:0] verb_letter(input int k, input int p);
    string w;
    w = verb_spelling(k);
    if (p < w.len()) begin
      return w[p];
    end
    return 8'h00;
  endfunction

  function automatic logic [2:0] matched_command();
    for (int k = 0; k < cltok_pkg::NUM_VERBS; k++) begin
      if (name_mask[k]) begin
        return VERB_CMD[k];
      end
    end
    return cltok_pkg::CODE_UNKNOWN;
  endfunction

  task automatic clear_line_state();
    tok_phase = cltok_pkg::PH_VERB;
    name_mask = cltok_pkg::ALL_NAMES;
    word_pos = '0;
    key_count = '0;
    value_count = '0;
  endtask

  task automatic push_word(input logic [1:0] kind, input logic [7:0] ch,
                           input logic [2:0] cmd, input logic [7:0] klen,
                           input logic [7:0] vlen);
    cltok_pkg::res_t w;
    w.kind = kind;
    w.token_char = ch;
    w.command = cmd;
    w.key_length = klen;
    w.value_length = vlen;
    pending_words.push_back(w);
  endtask

  task automatic close_word();
    logic [2:0] cmd;
    for (int k = 0; k < cltok_pkg::NUM_VERBS; k++) begin
      if (verb_length(k) != word_pos) begin
        name_mask[k] = 1'b0;
      end
    end
    cmd = matched_command();
    tok_phase = (cmd inside {cltok_pkg::CODE_READ, cltok_pkg::CODE_WRITE,
                             cltok_pkg::CODE_FORGET}) ?
                cltok_pkg::PH_GAP : cltok_pkg::PH_DONE;
  endtask

  task automatic take_key(input logic [7:0] c);
    push_word(cltok_pkg::KIND_KEY, c, cltok_pkg::CODE_UNKNOWN, 8'd0, 8'd0);
    key_count++;
  endtask

  task automatic tokenize_char(input logic [7:0] c);
    logic [2:0] cmd;
    cmd = matched_command();
    case (tok_phase)
      cltok_pkg::PH_VERB: begin
        if (c == cltok_pkg::CHAR_SPACE) begin
          close_word();
        end else begin
          for (int k = 0; k < cltok_pkg::NUM_VERBS; k++) begin
            if (word_pos >= verb_length(k) || verb_letter(k, word_pos) != c) begin
              name_mask[k] = 1'b0;
            end
          end
          if (word_pos < cltok_pkg::POS_MAX) begin
            word_pos++;
          end
        end
      end
      cltok_pkg::PH_GAP: begin
        if (c == cltok_pkg::CHAR_SPACE) begin
        end else if (cmd == cltok_pkg::CODE_WRITE) begin
          tok_phase = (c == cltok_pkg::CHAR_QUOTE) ? cltok_pkg::PH_QKEY : cltok_pkg::PH_DONE;
        end else if (cmd == cltok_pkg::CODE_READ && c == cltok_pkg::CHAR_QUOTE) begin
          tok_phase = cltok_pkg::PH_QKEY;
        end else if (key_count < cur_limit) begin
          tok_phase = cltok_pkg::PH_BARE;
          take_key(c);
        end else begin
          tok_phase = cltok_pkg::PH_DONE;
        end
      end
      cltok_pkg::PH_QKEY: begin
        if (c == cltok_pkg::CHAR_QUOTE) begin
          tok_phase = (cmd == cltok_pkg::CODE_WRITE) ? cltok_pkg::PH_WGAP : cltok_pkg::PH_DONE;
        end else if (key_count < cur_limit) begin
          take_key(c);
        end else begin
          tok_phase = (cmd == cltok_pkg::CODE_WRITE && c == cltok_pkg::CHAR_SPACE) ?
                      cltok_pkg::PH_WGAP : cltok_pkg::PH_DONE;
        end
      end
      cltok_pkg::PH_BARE: begin
        if (c == cltok_pkg::CHAR_SPACE) begin
          tok_phase = cltok_pkg::PH_DONE;
        end else if (key_count < cur_limit) begin
          take_key(c);
        end else begin
          tok_phase = cltok_pkg::PH_DONE;
        end
      end
      cltok_pkg::PH_WGAP: begin
        if (c != cltok_pkg::CHAR_SPACE) begin
          tok_phase = (c == cltok_pkg::CHAR_QUOTE) ? cltok_pkg::PH_WVAL : cltok_pkg::PH_DONE;
        end
      end
      cltok_pkg::PH_WVAL: begin
        if (c == cltok_pkg::CHAR_QUOTE) begin
          tok_phase = cltok_pkg::PH_DONE;
        end else if (value_count < cur_limit) begin
          push_word(cltok_pkg::KIND_VALUE, c, cltok_pkg::CODE_UNKNOWN, 8'd0, 8'd0);
          value_count++;
        end else begin
          tok_phase = cltok_pkg::PH_DONE;
        end
      end
      default: begin
        tok_phase = cltok_pkg::PH_DONE;
      end
    endcase
  endtask

  task automatic end_line();
    if (tok_phase == cltok_pkg::PH_VERB) begin
      close_word();
    end
    push_word(cltok_pkg::KIND_END, 8'h00, matched_command(), key_count, value_count);
    clear_line_state();
  endtask

  task automatic predict_item(input logic [7:0] c, input logic last);
    if (skip_rest) begin
      if (last) begin
        skip_rest = 1'b0;
      end
    end else if (c == cltok_pkg::CHAR_NUL) begin
      end_line();
      if (!last) begin
        skip_rest = 1'b1;
      end
    end else begin
      tokenize_char(c);
      if (last) begin
        end_line();
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_word();
    cltok_pkg::res_t want;
    if (pending_words.size() == 0) begin
      $error("Unexpected result word: kind %0d, char %0d, command %0d", out_ch.kind,
             out_ch.token_char, out_ch.command);
      fail_count++;
    end else begin
      want = pending_words.pop_front();
      compare_field("kind", want.kind, out_ch.kind);
      compare_field("token_char", want.token_char, out_ch.token_char);
      compare_field("command", want.command, out_ch.command);
      compare_field("key_length", want.key_length, out_ch.key_length);
      compare_field("value_length", want.value_length, out_ch.value_length);
    end
    case (out_ch.kind)
      cltok_pkg::KIND_KEY: key_words++;
      cltok_pkg::KIND_VALUE: value_words++;
      default: end_words++;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stuck_cycles = 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (out_ch.valid && out_ch.ready) begin
        check_word();
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Watchdog: no word moved for %0d cycles", STUCK_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (sink_busy && $urandom_range(0, 99) < 20) begin
        stall_left = $urandom_range(0, 7);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = source_idle ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.char_code <= c;
    in_ch.last_char <= last;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(c, last);
    burst_left--;
    chars_sent++;
  endtask

  task automatic send_line(input line_t ln);
    if (ln.size() == 0) begin
      send_char(cltok_pkg::CHAR_NUL, 1'b1);
    end else begin
      for (int i = 0; i < ln.size(); i++) begin
        send_char(ln[i], i == ln.size() - 1);
      end
    end
    lines_sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_words.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_limit_readback(input logic [7:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= LIMIT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    compare_field("token_limit readback", {24'h0, want}, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_limit(input logic [7:0] value);
    settle();
    apb_write(LIMIT_ADDR, {24'h0, value});
    cur_limit = value;
    limits_used++;
    check_limit_readback(value);
  endtask

  function automatic line_t spell(input string s);
    line_t q;
    q = {};
    for (int i = 0; i < s.len(); i++) begin
      q.push_back(s[i]);
    end
    return q;
  endfunction

  function automatic line_t spaces(input int lo, input int hi);
    line_t q;
    q = {};
    repeat ($urandom_range(lo, hi)) q.push_back(cltok_pkg::CHAR_SPACE);
    return q;
  endfunction

  function automatic line_t random_text(input int n, input bit loose);
    line_t q;
    logic [7:0] c;
    q = {};
    for (int i = 0; i < n; i++) begin
      c = 8'($urandom_range(1, 255));
      if (loose && $urandom_range(0, 7) == 0) begin
        c = $urandom_range(0, 1) ? cltok_pkg::CHAR_SPACE : cltok_pkg::CHAR_QUOTE;
      end
      while (!loose && (c == cltok_pkg::CHAR_SPACE || c == cltok_pkg::CHAR_QUOTE)) begin
        c = 8'($urandom_range(1, 255));
      end
      q.push_back(c);
    end
    return q;
  endfunction

  function automatic int token_len();
    int span;
    span = (cur_limit < 10) ? int'(cur_limit) + 2 : 10;
    return $urandom_range(0, span);
  endfunction

  function automatic string near_miss();
    case ($urandom_range(0, 6))
      0: return "REA";
      1: return "READS";
      2: return "WRIT";
      3: return "FORGE";
      4: return "PRINTS";
      5: return "read";
      default: return "CLEAr";
    endcase
  endfunction

  task automatic random_line();
    line_t ln;
    int pick;
    int style;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      case ($urandom_range(0, 9))
        0: ln = {spell("PRINT"), spaces(0, 2), random_text(token_len(), 1)};
        1: ln = {spell("CLEAR"), spaces(0, 2), random_text(token_len(), 1)};
        2, 3: begin
          ln = {spell("READ"), spaces(1, 3)};
          if ($urandom_range(0, 1)) begin
            ln = {ln, cltok_pkg::CHAR_QUOTE, random_text(token_len(), 0)};
            if ($urandom_range(0, 4) != 0) begin
              ln = {ln, cltok_pkg::CHAR_QUOTE, random_text($urandom_range(0, 3), 1)};
            end
          end else begin
            ln = {ln, random_text(token_len(), 0), spaces(0, 1),
                  random_text($urandom_range(0, 3), 1)};
          end
        end
        4, 5, 6: begin
          ln = {spell("WRITE"), spaces(1, 3)};
          if ($urandom_range(0, 5) != 0) begin
            ln = {ln, cltok_pkg::CHAR_QUOTE, random_text(token_len(), 0),
                  cltok_pkg::CHAR_QUOTE, spaces(0, 2), cltok_pkg::CHAR_QUOTE,
                  random_text(token_len(), 0), cltok_pkg::CHAR_QUOTE};
          end else begin
            ln = {ln, random_text(token_len() + 1, 1), spaces(0, 1),
                  random_text(token_len(), 1)};
          end
        end
        7, 8: ln = {spell("FORGET"), spaces(1, 2), random_text(token_len(), 1)};
        default: ln = {spell(near_miss()), spaces(1, 2), random_text(token_len(), 1)};
      endcase
    end else if (pick < 90) begin
      ln = random_text($urandom_range(1, 12), 1);
    end else begin
      ln = {spaces(1, 3), spell(verb_spelling($urandom_range(0, 4))), spaces(1, 1),
            random_text(token_len(), 0)};
    end

    style = $urandom_range(0, 9);
    if (style < 7 && ln.size() != 0) begin
      send_line(ln);
    end else begin
      foreach (ln[i]) begin
        send_char(ln[i], 1'b0);
      end
      if (style == 8) begin
        send_char(cltok_pkg::CHAR_NUL, 1'b0);
        repeat ($urandom_range(0, 3)) send_char(8'($urandom_range(0, 255)), 1'b0);
        send_char(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        send_char(cltok_pkg::CHAR_NUL, 1'b1);
      end
      lines_sent++;
    end
  endtask

  task automatic test_reset_value();
    check_limit_readback(cltok_pkg::TOKEN_LIMIT_RESET);
  endtask

  task automatic test_commands();
    source_idle = 1'b0;
    sink_busy = 1'b0;
    send_line(spell("PRINT"));
    send_line(spell("CLEAR x"));
    send_line(spell("READ ab"));
    send_line({spell("READ "), cltok_pkg::CHAR_QUOTE, spell("a b"), cltok_pkg::CHAR_QUOTE});
    send_line({spell("WRITE "), cltok_pkg::CHAR_QUOTE, spell("k"), cltok_pkg::CHAR_QUOTE,
               cltok_pkg::CHAR_SPACE, cltok_pkg::CHAR_QUOTE, spell("v"),
               cltok_pkg::CHAR_QUOTE});
    send_line({spell("FORGET "), cltok_pkg::CHAR_QUOTE, spell("q")});
  endtask

  task automatic test_special_cases();
    source_idle = 1'b1;
    sink_busy = 1'b1;
    send_char(cltok_pkg::CHAR_NUL, 1'b1);
    send_line(spell(" READ a"));
    send_line(spell("READ"));
    send_line(spell("WRITEWRITEWRITEWRITE a"));
    send_line(spell("WRITE key v"));
    send_line({spell("READ "), 8'hFF, 8'h01});
    send_char("R", 1'b0);
    send_char(cltok_pkg::CHAR_SPACE, 1'b0);
    send_char(cltok_pkg::CHAR_NUL, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(cltok_pkg::CHAR_NUL, 1'b0);
    send_char(8'h41, 1'b1);
    send_line(spell("PRINT"));
  endtask

  task automatic test_token_cap();
    source_idle = 1'b1;
    sink_busy = 1'b1;
    set_limit(8'd1);
    send_line({spell("WRITE "), cltok_pkg::CHAR_QUOTE, spell("ab"), cltok_pkg::CHAR_QUOTE,
               cltok_pkg::CHAR_SPACE, cltok_pkg::CHAR_QUOTE, spell("v"),
               cltok_pkg::CHAR_QUOTE});
    send_line({spell("WRITE "), cltok_pkg::CHAR_QUOTE, spell("a "), cltok_pkg::CHAR_QUOTE,
               spell("vw"), cltok_pkg::CHAR_QUOTE});
    send_line({spell("WRITE "), cltok_pkg::CHAR_QUOTE, spell("a"), cltok_pkg::CHAR_QUOTE,
               cltok_pkg::CHAR_QUOTE, spell("b"), cltok_pkg::CHAR_QUOTE});
    send_line(spell("READ xy"));
    set_limit(8'd255);
    send_line({spell("FORGET "), random_text(257, 0)});
    set_limit(8'd0);
    send_line({spell("WRITE "), cltok_pkg::CHAR_QUOTE, spell("a"), cltok_pkg::CHAR_QUOTE,
               cltok_pkg::CHAR_QUOTE, spell("b"), cltok_pkg::CHAR_QUOTE});
    send_line(spell("READ z"));
  endtask

  task automatic test_random_lines();
    logic [7:0] limits [6];
    int stop_at;
    int budget;
    limits = '{8'd32, 8'd1, 8'd3, 8'($urandom_range(4, 20)), 8'd255,
               8'($urandom_range(1, 255))};
    for (int p = 0; p < 6; p++) begin
      set_limit(limits[p]);
      source_idle = (p != 2);
      sink_busy = (p != 2);
      budget = (ITEM_TARGET - chars_sent) / (6 - p);
      if (budget < 12) begin
        budget = 12;
      end
      stop_at = chars_sent + budget;
      while (chars_sent < stop_at) begin
        random_line();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.char_code = 8'h00;
    in_ch.last_char = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cur_limit = cltok_pkg::TOKEN_LIMIT_RESET;
    skip_rest = 1'b0;
    clear_line_state();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_value();
    test_commands();
    test_special_cases();
    test_token_cap();
    test_random_lines();
    settle();

    $display("Covered %0d characters in %0d lines over %0d token limit settings.",
             chars_sent, lines_sent, limits_used);
    $display("Checked %0d key, %0d value and %0d line-end words.", key_words,
             value_words, end_words);
    if (fail_count == 0 && pending_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/cltok_pkg.sv
rtl/cltok_if.sv
rtl/cltok_cfg.sv
rtl/cltok_parse.sv
rtl/cltok_outq.sv
rtl/command_line_tokenizer_core.sv
tb/sv/command_line_tokenizer_core_tb.sv
